@@ rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// shared constants, types and helpers of the sensor frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int BUFFER_DEPTH = 32;
  localparam int FRAME_MAX    = 15;
  localparam int POS_W        = 6;
  localparam int NUM_CAPTURE  = 9;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = QPTR_W + 1;
  localparam int TEMP_SCALE   = 10;

  localparam logic [7:0] CH_START = 8'h23;
  localparam logic [7:0] CH_END   = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;

  // capture slot indexes
  localparam int SLOT_DEST   = 0;
  localparam int SLOT_SENDER = 1;
  localparam int SLOT_TEMP_H = 2;
  localparam int SLOT_TEMP_L = 3;
  localparam int SLOT_CO_H   = 4;
  localparam int SLOT_CO_L   = 5;
  localparam int SLOT_CO2_H  = 6;
  localparam int SLOT_CO2_L  = 7;
  localparam int SLOT_HUM    = 8;

  typedef logic [7:0] byte_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef byte_t [NUM_CAPTURE-1:0] capture_t;

  // classified word handed from front to back
  typedef struct packed {
    logic        overrun;
    logic        frame_end;
    logic        frame_valid;
    logic [1:0]  sensor_id;
    byte_t       temp_hi;
    byte_t       temp_lo;
    byte_t       humidity;
    logic [15:0] co_level;
    logic [15:0] co2_level;
  } rec_t;

  // frame position held by a capture slot
  function automatic pos_t slot_pos(input int slot);
    pos_t p;
    p = '0;
    case (slot)
      SLOT_DEST:   p = pos_t'(1);
      SLOT_SENDER: p = pos_t'(2);
      default:     p = pos_t'(slot + 4);
    endcase
    return p;
  endfunction

endpackage

@@ rtl/sfr_if.sv @@
// ----------------------------------------------------------------------------
// sfr_in_if / sfr_out_if
// valid-ready channels for received bytes and decoded results
// ----------------------------------------------------------------------------
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic        overrun;
  logic        frame_end;
  logic        frame_valid;
  logic [1:0]  sensor_id;
  logic [11:0] temp_tenths;
  logic [7:0]  humidity;
  logic [15:0] co_level;
  logic [15:0] co2_level;

  modport source (output valid, output overrun, output frame_end, output frame_valid,
                  output sensor_id, output temp_tenths, output humidity,
                  output co_level, output co2_level, input ready);
  modport sink (input valid, input overrun, input frame_end, input frame_valid,
                input sensor_id, input temp_tenths, input humidity,
                input co_level, input co2_level, output ready);
endinterface

@@ rtl/sfr_front.sv @@
// ----------------------------------------------------------------------------
// sfr_front
// tracks frame position, checksum and captured bytes, classifies each word
// ----------------------------------------------------------------------------
module sfr_front (
  input  logic          clk,
  input  logic          rst,
  sfr_in_if.sink        rx,
  input  logic          q_full,
  output logic          push,
  output sfr_pkg::rec_t push_data
);
  import sfr_pkg::*;

  pos_t     write_position, write_position_next;
  byte_t    running_sum, running_sum_next;
  byte_t    previous_byte;
  capture_t captured_bytes, captured_bytes_next;

  pos_t  pos_eff;
  pos_t  p;
  logic  ov;
  logic  fend;
  logic  fvalid;

  assign rx.ready = !q_full;
  assign push     = rx.valid && rx.ready;

  always_comb begin
    pos_eff = (rx.rx_byte == CH_START) ? '0 : write_position;
    ov      = pos_eff >= pos_t'(BUFFER_DEPTH);
    p       = ov ? '0 : pos_eff;
    captured_bytes_next = captured_bytes;
    for (int i = 0; i < NUM_CAPTURE; i++) begin
      if (p == slot_pos(i)) captured_bytes_next[i] = rx.rx_byte;
    end
    running_sum_next    = (p == '0) ? '0 : byte_t'(running_sum + previous_byte);
    write_position_next = pos_t'(p + pos_t'(1));
  end

  always_comb begin
    fend   = rx.rx_byte == CH_END;
    fvalid = fend && (p >= pos_t'(2)) && (p <= pos_t'(FRAME_MAX - 1)) &&
             (previous_byte == running_sum) &&
             (captured_bytes_next[SLOT_DEST] == CH_ZERO) &&
             (captured_bytes_next[SLOT_SENDER] inside {[CH_ONE:CH_THREE]});
    push_data             = '0;
    push_data.overrun     = ov;
    push_data.frame_end   = fend;
    push_data.frame_valid = fvalid;
    if (fvalid) begin
      push_data.sensor_id = 2'(captured_bytes_next[SLOT_SENDER] - CH_ZERO);
      push_data.temp_hi   = captured_bytes_next[SLOT_TEMP_H];
      push_data.temp_lo   = captured_bytes_next[SLOT_TEMP_L];
      push_data.humidity  = captured_bytes_next[SLOT_HUM];
      push_data.co_level  = {captured_bytes_next[SLOT_CO_H], captured_bytes_next[SLOT_CO_L]};
      push_data.co2_level = {captured_bytes_next[SLOT_CO2_H],
                             captured_bytes_next[SLOT_CO2_L]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      running_sum    <= '0;
      previous_byte  <= '0;
      captured_bytes <= '0;
    end else if (push) begin
      write_position <= write_position_next;
      running_sum    <= running_sum_next;
      previous_byte  <= rx.rx_byte;
      captured_bytes <= captured_bytes_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_restart_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (push && rx.rx_byte == CH_START) |-> !push_data.overrun)
    else $error("restart byte raised overrun");
  a_valid_needs_end: assert property (@(posedge clk) disable iff (rst)
    push_data.frame_valid |-> push_data.frame_end)
    else $error("valid frame without terminator");
  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    write_position <= pos_t'(BUFFER_DEPTH))
    else $error("write position beyond buffer");
`endif

endmodule

@@ rtl/sfr_queue.sv @@
// ----------------------------------------------------------------------------
// sfr_queue
// short fifo between classification and result output
// ----------------------------------------------------------------------------
module sfr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfr_pkg::rec_t push_data,
  output logic          full,
  input  logic          pop,
  output sfr_pkg::rec_t pop_data,
  output logic          not_empty
);
  import sfr_pkg::*;

  rec_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = count == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !not_empty |-> !pop)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

@@ rtl/sfr_back.sv @@
// ----------------------------------------------------------------------------
// sfr_back
// scales temperature and holds the result word for the sink
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  sfr_pkg::rec_t q_data,
  output logic          pop,
  sfr_out_if.source     res
);
  import sfr_pkg::*;

  logic        full;
  logic [11:0] temp;

  assign pop       = q_valid && (!full || res.ready);
  assign res.valid = full;
  assign temp      = 12'(12'(q_data.temp_hi) * 12'(TEMP_SCALE)) + 12'(q_data.temp_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (pop) begin
      full <= 1'b1;
    end else if (res.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.overrun     <= q_data.overrun;
      res.frame_end   <= q_data.frame_end;
      res.frame_valid <= q_data.frame_valid;
      res.sensor_id   <= q_data.sensor_id;
      res.temp_tenths <= temp;
      res.humidity    <= q_data.humidity;
      res.co_level    <= q_data.co_level;
      res.co2_level   <= q_data.co2_level;
    end
  end

`ifndef NO_ASSERTIONS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.frame_valid) |->
      (res.sensor_id == '0 && res.temp_tenths == '0 && res.humidity == '0 &&
       res.co_level == '0 && res.co2_level == '0))
    else $error("fields set on invalid frame");
  a_valid_sensor: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.frame_valid) |-> (res.sensor_id != '0 && res.frame_end))
    else $error("valid frame with bad sender or no end");
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    pop |=> res.valid)
    else $error("loaded word not shown");
`endif

endmodule

@@ rtl/sensor_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// sensor_frame_receiver_top
// sensor frame receiver: byte stream in, one decoded word out per byte
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  rx       in   rx_byte
//  res      out  overrun, frame_end, frame_valid, sensor_id, temp_tenths,
//                humidity, co_level, co2_level
//
//  one byte per cycle while res is ready; results pass queue and output register
//  the front updates position, checksum and captures in the accepting cycle
//  a two-word queue and an output register decouple rx from res stalls
//  rst is synchronous and clears position, checksum, captures and queue
// ----------------------------------------------------------------------------
module sensor_frame_receiver_top (
  input  logic      clk,
  input  logic      rst,
  sfr_in_if.sink    rx,
  sfr_out_if.source res
);
  import sfr_pkg::*;

  logic q_full;
  logic push;
  rec_t push_data;
  logic pop;
  rec_t pop_data;
  logic q_valid;

  sfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  sfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid)
  );

  sfr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (pop_data),
    .pop     (pop),
    .res     (res)
  );

endmodule
